// ===== rtl/vumb_pkg.sv =====
// ----------------------------------------------------------------------------
// vumb_pkg
// Shared types, constants and helpers for the VU meter bar with peak falloff.
// ----------------------------------------------------------------------------
package vumb_pkg;

  // Meter and strip limits, peak format.
  localparam int MAX_METER_LEDS     = 64;
  localparam int MAX_STRIP_LEDS     = 256;
  localparam int PEAK_FRACTION_BITS = 8;
  localparam int PEAK_W             = 15;
  localparam int LEN_W              = 7;
  localparam int COUNT_W            = PEAK_W - PEAK_FRACTION_BITS;
  localparam int START_W            = 9;
  localparam int STRIP_W            = 9;
  localparam int DEC_W              = 32;
  localparam int FULL_SCALE         = 256;
  localparam int FULL_SCALE_SHIFT   = 8;
  localparam int POS_W              = 11;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_METER_LENGTH   = 3'd0,
    REG_START_POSITION = 3'd1,
    REG_STRIP_LENGTH   = 3'd2,
    REG_REVERSE_ORDER  = 3'd3,
    REG_DECAY_PER_MS   = 3'd4
  } reg_index_t;

  // Input beat.
  typedef struct packed {
    logic [8:0]  volume;
    logic [15:0] elapsed_ms;
    logic [7:0]  start_offset;
  } in_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] led_index;
    logic       lit;
    logic       last;
  } out_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [6:0]  meter_length;
    logic [7:0]  start_position;
    logic [8:0]  strip_length;
    logic        reverse_order;
    logic [15:0] decay_per_ms;
  } cfg_t;

  // One frame as handed from the front part to the back part.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [START_W-1:0] start;
  } frame_t;

  // Meter length limited to the supported number of LEDs.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [6:0] len);
    logic [LEN_W-1:0] r;
    if (32'(len) > MAX_METER_LEDS) begin
      r = LEN_W'(MAX_METER_LEDS);
    end else begin
      r = len;
    end
    return r;
  endfunction

  // Strip length limited to the supported number of LEDs.
  function automatic logic [STRIP_W-1:0] clamp_strip(input logic [8:0] n);
    logic [STRIP_W-1:0] r;
    if (32'(n) > MAX_STRIP_LEDS) begin
      r = STRIP_W'(MAX_STRIP_LEDS);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

// ===== rtl/vumb_regs.sv =====
// ----------------------------------------------------------------------------
// vumb_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module vumb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vumb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vumb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vumb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output vumb_pkg::cfg_t                  cfg
);
  import vumb_pkg::*;

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.meter_length   <= 7'd16;
      cfg.start_position <= 8'd0;
      cfg.strip_length   <= 9'd64;
      cfg.reverse_order  <= 1'b0;
      cfg.decay_per_ms   <= 16'd16;
    end else if (wr_en) begin
      case (index)
        REG_METER_LENGTH:   cfg.meter_length   <= pwdata[6:0];
        REG_START_POSITION: cfg.start_position <= pwdata[7:0];
        REG_STRIP_LENGTH:   cfg.strip_length   <= pwdata[8:0];
        REG_REVERSE_ORDER:  cfg.reverse_order  <= pwdata[0];
        REG_DECAY_PER_MS:   cfg.decay_per_ms   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_METER_LENGTH:   prdata = CFG_DATA_W'(cfg.meter_length);
      REG_START_POSITION: prdata = CFG_DATA_W'(cfg.start_position);
      REG_STRIP_LENGTH:   prdata = CFG_DATA_W'(cfg.strip_length);
      REG_REVERSE_ORDER:  prdata = CFG_DATA_W'(cfg.reverse_order);
      REG_DECAY_PER_MS:   prdata = CFG_DATA_W'(cfg.decay_per_ms);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== rtl/vumb_front.sv =====
// ----------------------------------------------------------------------------
// vumb_front
// Accepts frames, decays and raises the held peak, and works out the lit count.
// ----------------------------------------------------------------------------
module vumb_front (
  input  logic             clk,
  input  logic             rst,
  input  vumb_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  vumb_pkg::in_t    in_data,
  output logic             push,
  input  logic             push_ready,
  output vumb_pkg::frame_t push_frame
);
  import vumb_pkg::*;

  // Stage 1: decay amount and volume count, registered.
  logic                 s1_valid;
  logic [DEC_W-1:0]     s1_dec;
  logic [COUNT_W-1:0]   s1_vcount;
  logic [7:0]           s1_offset;

  // Held peak, LED units with fraction bits.
  logic [PEAK_W-1:0]    peak;
  logic [PEAK_W-1:0]    peak_next;

  logic                 in_accept;
  logic [8:0]           vol_c;
  logic [LEN_W-1:0]     len;
  logic [15:0]          vol_prod;
  logic [15:0]          vol_sum;
  logic [PEAK_W-1:0]    decayed;
  logic [COUNT_W-1:0]   pint;
  logic [PEAK_W-1:0]    raised;

  assign len       = clamp_len(cfg.meter_length);
  assign vol_c     = (32'(in_data.volume) > FULL_SCALE) ? 9'(FULL_SCALE) : in_data.volume;
  assign vol_prod  = 16'(vol_c) * 16'(len);
  assign vol_sum   = vol_prod + 16'(FULL_SCALE - 1);

  assign in_ready  = !s1_valid || push_ready;
  assign in_accept = in_valid && in_ready;
  assign push      = s1_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_dec    <= DEC_W'(in_data.elapsed_ms) * DEC_W'(cfg.decay_per_ms);
      s1_vcount <= vol_sum[FULL_SCALE_SHIFT +: COUNT_W];
      s1_offset <= in_data.start_offset;
    end
  end

  // Linear decay saturating at zero, then a higher volume count lifts the peak.
  always_comb begin
    if (DEC_W'(peak) > s1_dec) begin
      decayed = peak - s1_dec[PEAK_W-1:0];
    end else begin
      decayed = '0;
    end
    pint   = decayed[PEAK_W-1:PEAK_FRACTION_BITS];
    raised = {s1_vcount, {PEAK_FRACTION_BITS{1'b0}}};
    if (raised > decayed) begin
      peak_next = raised;
    end else begin
      peak_next = decayed;
    end
    push_frame.count = (s1_vcount > pint) ? s1_vcount : pint;
    push_frame.start = START_W'(cfg.start_position) + START_W'(s1_offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
    end else if (push) begin
      peak <= peak_next;
    end
  end

endmodule

// ===== rtl/vumb_queue.sv =====
// ----------------------------------------------------------------------------
// vumb_queue
// Small first-word-fall-through queue of frames between front and back.
// ----------------------------------------------------------------------------
module vumb_queue #(
  parameter int DEPTH = vumb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  vumb_pkg::frame_t push_frame,
  output logic             head_valid,
  input  logic             pop,
  output vumb_pkg::frame_t head
);
  import vumb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_t          store [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill != CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;
  assign head       = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_frame;
    end
  end

endmodule

// ===== rtl/vumb_back.sv =====
// ----------------------------------------------------------------------------
// vumb_back
// Walks the bar of the frame at the queue head, one LED beat per cycle while the output is free.
// ----------------------------------------------------------------------------
module vumb_back (
  input  logic             clk,
  input  logic             rst,
  input  vumb_pkg::cfg_t   cfg,
  input  logic             head_valid,
  input  vumb_pkg::frame_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output vumb_pkg::out_t   out_data
);
  import vumb_pkg::*;

  logic [LEN_W-1:0]         led;
  logic [LEN_W-1:0]         led_next;
  logic [LEN_W-1:0]         len;
  logic [STRIP_W-1:0]       n;
  logic                     out_free;
  logic                     emit;
  logic                     is_last;
  logic signed [POS_W-1:0]  pos_raw;
  logic signed [POS_W-1:0]  pos_lo;
  logic signed [POS_W-1:0]  pos;
  out_t                     beat;

  assign len      = clamp_len(cfg.meter_length);
  assign n        = clamp_strip(cfg.strip_length);
  assign out_free = !out_valid || out_ready;
  assign is_last  = (led + 1'b1) == len;
  assign emit     = head_valid && (len != '0) && out_free;
  // A frame on a zero-length bar leaves without any beat.
  assign pop      = head_valid && ((len == '0) || (emit && is_last));
  assign led_next = (emit && is_last) ? '0 : (emit ? led + 1'b1 : led);

  // Single wrap around the strip in each direction.
  always_comb begin
    if (cfg.reverse_order) begin
      pos_raw = POS_W'(head.start) - POS_W'(led);
    end else begin
      pos_raw = POS_W'(head.start) + POS_W'(led);
    end
    if (pos_raw < 0) begin
      pos_lo = pos_raw + POS_W'(n);
    end else begin
      pos_lo = pos_raw;
    end
    if (pos_lo >= $signed(POS_W'(n))) begin
      pos = pos_lo - POS_W'(n);
    end else begin
      pos = pos_lo;
    end
    beat.led_index = pos[7:0];
    beat.lit       = (COUNT_W'(led) < head.count);
    beat.last      = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led       <= '0;
      out_valid <= 1'b0;
    end else begin
      led <= led_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= beat;
    end
  end

endmodule

// ===== rtl/vu_meter_bar_with_peak_falloff.sv =====
// ----------------------------------------------------------------------------
// vu_meter_bar_with_peak_falloff
// LED bar-graph VU meter with a linearly falling peak hold.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one display frame (volume, milliseconds since
// the previous frame, start offset). For every frame the block sends one
// output beat per meter LED, in bar order, giving the strip index and whether
// the LED is lit; the final beat of the frame has last set. A frame on a
// zero-length bar updates the peak but sends nothing.
// A frame passes the front stage-1 register and the frame queue, and its beats
// leave through the output register. The output walker sends one beat per
// cycle while the receiver takes beats.
// The front part takes a new frame every cycle while the frame queue has
// room, so frames stream back to back with no gap between bars.
// Reset clears the held peak, empties the queue and the output register and
// restores the register defaults. When the receiver stalls, the output beat
// holds, the walker waits, the queue fills and the input side then stops.
// The user must write registers over the APB-style port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module vu_meter_bar_with_peak_falloff #(
  parameter int QUEUE_DEPTH = vumb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Frame input.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vumb_pkg::in_t                   in_data,
  // LED result output.
  output logic                            out_valid,
  input  logic                            out_ready,
  output vumb_pkg::out_t                  out_data,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vumb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vumb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vumb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import vumb_pkg::*;

  cfg_t   cfg;
  logic   push;
  logic   push_ready;
  frame_t push_frame;
  logic   head_valid;
  logic   pop;
  frame_t head;

  // Register file: meter geometry and decay rate.
  vumb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front part: decay multiply in the first stage, then the peak update and
  // lit count as the frame enters the queue.
  vumb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_ready (push_ready),
    .push_frame (push_frame)
  );

  // The queue lets the front keep taking frames while a bar is still being sent.
  vumb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  // Back part: one LED beat per cycle, while the output is free, into a registered output stage.
  vumb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the VU meter bar with a linearly falling peak hold.
// ----------------------------------------------------------------------------
// Frames are queued by the stimulus process and sent by a clocked driver. The
// driver also runs each accepted frame through a local model of the meter.
// That model decays the peak, works out the lit count and lists the strip
// index of every bar LED, and its output is queued as expected LED beats. A
// clocked monitor takes each output beat and compares it field by field with
// the oldest expected beat. The run steps through several register settings,
// the limits among them, and through four idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import vumb_pkg::*;

  // Frames per random phase, and the pause before a register write. A frame
  // on a zero-length bar sends nothing, so the bench cannot see when the
  // block has finished with it. The pause lets such a frame pass the stage-1
  // register and the queue with a wide margin.
  localparam int FRAMES_PER_PHASE = 45;
  localparam int SETTLE_CYCLES    = 16;
  localparam int N_PHASES         = 9;

  // Watchdog. A correct run needs about 420 frames of up to 64 beats each,
  // and the limit leaves a wide margin for receiver stalls.
  localparam int WATCHDOG_CYCLES = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every block input starts at a known value.
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  vu_meter_bar_with_peak_falloff uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Frames waiting to be sent, and LED beats the meter is due to send.
  in_t  frames_pending[$];
  out_t led_beats_due[$];

  // Idle behavior of each side, in percent of cycles.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int n_mismatch     = 0;

  // The model's copy of the registers, at their reset values, and of the held
  // peak in LED units with eight fraction bits.
  logic [6:0]  bar_len    = 7'd16;
  logic [7:0]  bar_start  = 8'd0;
  logic [8:0]  strip_leds = 9'd64;
  logic        bar_down   = 1'b0;
  logic [15:0] fall_rate  = 16'd16;
  logic [14:0] peak_q8    = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the LED beats for one frame and update the held peak. The peak
  // falls first. The bar then shows the larger of the volume count and the
  // whole part of the peak, and a volume count above the peak raises it.
  task automatic light_bar(input in_t f);
    int   len;
    int   n;
    int   vol;
    int   vcount;
    int   pint;
    int   lit_count;
    int   first;
    int   pos;
    logic [31:0] drop;
    int   raised;
    out_t b;
    len = (int'(bar_len) > MAX_METER_LEDS) ? MAX_METER_LEDS : int'(bar_len);
    n   = (int'(strip_leds) > MAX_STRIP_LEDS) ? MAX_STRIP_LEDS : int'(strip_leds);
    vol = (int'(f.volume) > FULL_SCALE) ? FULL_SCALE : int'(f.volume);

    // The drop is at most 32 bits wide, and the peak stops at zero.
    drop = 32'(fall_rate) * 32'(f.elapsed_ms);
    if (32'(peak_q8) > drop) begin
      peak_q8 = peak_q8 - drop[14:0];
    end else begin
      peak_q8 = '0;
    end

    vcount    = (vol * len + FULL_SCALE - 1) / FULL_SCALE;
    pint      = int'(peak_q8) >> PEAK_FRACTION_BITS;
    lit_count = (vcount > pint) ? vcount : pint;
    raised    = vcount << PEAK_FRACTION_BITS;
    if (raised > int'(peak_q8)) begin
      peak_q8 = (raised > 32'h7fff) ? 15'h7fff : 15'(raised);
    end

    // Walk the bar. The wrap is applied once in each direction, so a position
    // that is still off the strip goes out as its low eight bits.
    first = int'(bar_start) + int'(f.start_offset);
    for (int i = 0; i < len; i++) begin
      pos = bar_down ? first - i : first + i;
      if (pos < 0) begin
        pos += n;
      end
      if (pos >= n) begin
        pos -= n;
      end
      b.led_index = pos[7:0];
      b.lit       = (i < lit_count);
      b.last      = (i + 1 == len);
      led_beats_due.push_back(b);
    end
  endtask

  // Frame driver. A new frame is loaded when the channel is free or its beat
  // is being taken at this edge. Otherwise the current beat holds.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        light_bar(in_data);
      end
      if (!in_valid || in_ready) begin
        if (frames_pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data  <= frames_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // LED beat monitor. Every taken beat must match the oldest expected beat.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (led_beats_due.size() == 0) begin
          $error("unexpected LED beat: led_index %0d lit %0b last %0b",
                 out_data.led_index, out_data.lit, out_data.last);
          n_mismatch++;
        end else begin
          out_t e;
          e = led_beats_due.pop_front();
          if (out_data.led_index !== e.led_index) begin
            $error("led_index: expected %0d, got %0d", e.led_index, out_data.led_index);
            n_mismatch++;
          end
          if (out_data.lit !== e.lit) begin
            $error("lit: expected %0b, got %0b", e.lit, out_data.lit);
            n_mismatch++;
          end
          if (out_data.last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_data.last);
            n_mismatch++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One register write: a setup phase, then an access phase. The register
  // takes the value at the edge that ends the access phase.
  task automatic cfg_write(input reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_METER_LENGTH:   bar_len    = val[6:0];
      REG_START_POSITION: bar_start  = val[7:0];
      REG_STRIP_LENGTH:   strip_leds = val[8:0];
      REG_REVERSE_ORDER:  bar_down   = val[0];
      REG_DECAY_PER_MS:   fall_rate  = val[15:0];
      default: ;
    endcase
  endtask

  // Wait until every frame is sent and every expected beat has come back.
  // Then let the block finish any frame on a zero-length bar.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (frames_pending.size() != 0 || in_valid || led_beats_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register settings per phase: the limits, values past the limits that the
  // fields still allow, a zero-length bar and strip, and random settings.
  task automatic apply_setup(input int ph);
    logic [31:0] v[5];
    case (ph)
      1:       v = '{64, 255, 256, 1, 0};
      2:       v = '{1, 0, 1, 0, 65535};
      3:       v = '{0, 10, 64, 0, 16};
      4:       v = '{127, 200, 511, 1, 300};
      5:       v = '{33, 128, 0, 1, 5};
      6:       v = '{64, 0, 256, 0, 1};
      default: v = '{$urandom_range(64, 1), $urandom_range(255), $urandom_range(256, 1),
                     $urandom_range(1), $urandom_range(600)};
    endcase
    cfg_write(REG_METER_LENGTH, v[0]);
    cfg_write(REG_START_POSITION, v[1]);
    cfg_write(REG_STRIP_LENGTH, v[2]);
    cfg_write(REG_REVERSE_ORDER, v[3]);
    cfg_write(REG_DECAY_PER_MS, v[4]);
  endtask

  // Random frame. Short gaps between frames dominate, so the peak hold and
  // its slow fall show up across frames. Loud frames raise the peak, and now
  // and then a long gap or a volume past full scale breaks the pattern.
  function automatic in_t rand_frame();
    in_t f;
    int  r;
    r = $urandom_range(99);
    if (r < 10) begin
      f.volume = 9'($urandom_range(511, 257));
    end else if (r < 25) begin
      f.volume = 9'd0;
    end else begin
      f.volume = 9'($urandom_range(256));
    end
    r = $urandom_range(99);
    if (r < 60) begin
      f.elapsed_ms = 16'($urandom_range(20));
    end else if (r < 85) begin
      f.elapsed_ms = 16'($urandom_range(300));
    end else begin
      f.elapsed_ms = 16'($urandom);
    end
    f.start_offset = 8'($urandom_range(255));
    return f;
  endfunction

  // Frames for the reset settings (16 LEDs, 64-LED strip, falloff 16 per ms):
  // silence, full scale, a one-step fall, a fall to zero from a long gap,
  // volume past full scale, the smallest volume rounding up to one LED, and
  // start offsets that wrap or stay off the strip.
  function automatic void load_directed();
    in_t f;
    f = '{9'd0,   16'd0,     8'd0};   frames_pending.push_back(f);
    f = '{9'd256, 16'd0,     8'd0};   frames_pending.push_back(f);
    f = '{9'd0,   16'd1,     8'd0};   frames_pending.push_back(f);
    f = '{9'd0,   16'd10,    8'd5};   frames_pending.push_back(f);
    f = '{9'd511, 16'd0,     8'd255}; frames_pending.push_back(f);
    f = '{9'd0,   16'd65535, 8'd0};   frames_pending.push_back(f);
    f = '{9'd1,   16'd0,     8'd60};  frames_pending.push_back(f);
    f = '{9'd128, 16'd0,     8'd48};  frames_pending.push_back(f);
    f = '{9'd257, 16'd3,     8'd1};   frames_pending.push_back(f);
    f = '{9'd0,   16'd0,     8'd63};  frames_pending.push_back(f);
    f = '{9'd200, 16'd65535, 8'd128}; frames_pending.push_back(f);
  endfunction

  // Stimulus: reset once, then the phases. Registers change only once the
  // block is drained. The idle pattern cycles through none, sender gaps,
  // receiver stalls and both.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        apply_setup(ph);
      end
      case (ph % 4)
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_gap_pct = 46; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 46; end
        default: begin send_gap_pct = 34; recv_stall_pct = 34; end
      endcase
      if (ph == 0) begin
        load_directed();
      end
      for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
        frames_pending.push_back(rand_frame());
      end
    end
    wait_drained();
    if (n_mismatch == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(WATCHDOG_CYCLES * 10);
    $display("status: fail");
    $finish;
  end

endmodule
